// File: sv/tile_pattern_color_decoder_macros.svh
// ---------------------------------------------------------------------------
// Tile pattern color decoder assertion macros
// Short forms for the concurrent checks of the block's checker.
// ---------------------------------------------------------------------------
`ifndef TILE_PATTERN_COLOR_DECODER_MACROS_SVH
`define TILE_PATTERN_COLOR_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tpcd_pkg.sv
// ---------------------------------------------------------------------------
// Tile pattern color decoder package
// Shared constants, register indexes and item kinds.
// ---------------------------------------------------------------------------
package tpcd_pkg;

  localparam int DEF_ROM_BYTES      = 65536;
  localparam int DEF_TILES_PER_AXIS = 64;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int TPR_W      = 7;
  localparam int TILE_W     = 13;
  localparam int LINE_OFF_W = 16;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TILES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ROW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_LENGTH  = 3'd5;

  localparam logic [TPR_W-1:0] RST_ROW_TILES = 7'd32;

  localparam logic OP_WRITE = 1'b0;

  // Color modes; the unused code three behaves as one color byte per 8 tiles.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LINE = 2'd2;

  // Classification made by the front part.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SKIP   = 2'd1;
  localparam logic [1:0] KIND_BLANK  = 2'd2;
  localparam logic [1:0] KIND_RENDER = 2'd3;

  // Fixed colors when no color table is used: fg 15 high, bg 0 low.
  localparam logic [7:0] COLOR_NONE = 8'hF0;

endpackage

// File: sv/tile_pattern_color_decoder.sv
// ---------------------------------------------------------------------------
// Tile pattern color decoder
// Decodes one 8-pixel tile line from a loaded byte image into color indices.
// ---------------------------------------------------------------------------
// Input items arrive on s_*: s_tuser is op, 0 writes one byte into the store
// and 1 asks for one tile line. A write item gives no result; a line item
// gives one result on m_*, eight 4-bit indices in m_tdata and the column
// active flag in m_tuser.
// In the back part a line item first makes the two store reads (pattern and
// color byte, made together on two read ports) and then forms the pixels; no
// new item leaves the queue while it forms them. Write items are taken at one
// item per cycle while the geometry unit is idle and no line is being formed.
// An inactive column's result is registered as its item leaves the queue.
// Any configuration write restarts the view geometry unit, which divides
// the loaded tile count by the tiles per row one bit a cycle; s_tready is
// low while it goes through its load, divide, top row and multiply states.
// Reset clears the queue and control state and loads the register defaults;
// store contents are undefined until written.
// When m_tready is low the result holds in the output register, the short
// queue keeps taking items until full, and then s_tready drops.
// ---------------------------------------------------------------------------
module tile_pattern_color_decoder #(
  parameter int ROM_BYTES      = tpcd_pkg::DEF_ROM_BYTES,
  parameter int TILES_PER_AXIS = tpcd_pkg::DEF_TILES_PER_AXIS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // write_addr[15:0], write_byte[23:16], tile row [29:24], tile column [35:30],
  // line_in_tile[38:36], zero fill [39]
  input  logic [tpcd_pkg::IN_DATA_W-1:0]  s_tdata,
  // op
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_indices[31:0]
  output logic [tpcd_pkg::OUT_DATA_W-1:0] m_tdata,
  // column_active
  output logic                            m_tuser,
  input  logic                            cfg_we,
  input  logic [tpcd_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tpcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W   = $clog2(ROM_BYTES + 1);
  localparam int ADDR_W  = ((LEN_W > 17) ? LEN_W : 17) + 2;
  localparam int ENTRY_W = 2 * ADDR_W + 11;

  logic [tpcd_pkg::TPR_W-1:0] row_tiles;
  logic [2:0]                 fine_offset;
  logic [1:0]                 color_mode;
  logic [15:0]                color_base;
  logic [15:0]                scroll_req;
  logic [16:0]                rom_length;

  logic [tpcd_pkg::TPR_W-1:0] tpr;
  logic [ADDR_W-1:0]          len;
  logic                       geom_busy;
  logic [ADDR_W-1:0]          base;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_full;
  logic                       q_empty;
  logic [ENTRY_W-1:0]         push_entry;
  logic [ENTRY_W-1:0]         head_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_tiles   <= tpcd_pkg::RST_ROW_TILES;
      fine_offset <= '0;
      color_mode  <= tpcd_pkg::MODE_NONE;
      color_base  <= '0;
      scroll_req  <= '0;
      rom_length  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tpcd_pkg::CFG_ROW_TILES:   row_tiles   <= cfg_data[6:0];
        tpcd_pkg::CFG_FINE_OFFSET: fine_offset <= cfg_data[2:0];
        tpcd_pkg::CFG_COLOR_MODE:  color_mode  <= cfg_data[1:0];
        tpcd_pkg::CFG_COLOR_BASE:  color_base  <= cfg_data[15:0];
        tpcd_pkg::CFG_SCROLL_ROW:  scroll_req  <= cfg_data[15:0];
        tpcd_pkg::CFG_ROM_LENGTH:  rom_length  <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // Tiles per row is taken within 1..TILES_PER_AXIS, the length within the store.
  assign tpr = (row_tiles == '0) ? tpcd_pkg::TPR_W'(1)
             : (row_tiles > tpcd_pkg::TPR_W'(TILES_PER_AXIS))
               ? tpcd_pkg::TPR_W'(TILES_PER_AXIS) : row_tiles;
  assign len = (ADDR_W'(rom_length) < ADDR_W'(ROM_BYTES)) ? ADDR_W'(rom_length)
                                                          : ADDR_W'(ROM_BYTES);

  tpcd_geom #(
    .TILES_PER_AXIS (TILES_PER_AXIS),
    .ADDR_W         (ADDR_W)
  ) u_geom (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_we),
    .len     (len),
    .tpr     (tpr),
    .scroll  (scroll_req),
    .busy    (geom_busy),
    .base    (base)
  );

  tpcd_front #(
    .ROM_BYTES (ROM_BYTES),
    .ADDR_W    (ADDR_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .op           (s_tuser),
    .write_addr   (s_tdata[15:0]),
    .write_byte   (s_tdata[23:16]),
    .row_idx      (s_tdata[29:24]),
    .col_idx      (s_tdata[35:30]),
    .line_in_tile (s_tdata[38:36]),
    .geom_busy    (geom_busy),
    .base         (base),
    .tpr          (tpr),
    .fine_offset  (fine_offset),
    .color_mode   (color_mode),
    .color_base   (color_base),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  tpcd_queue #(
    .W     (ENTRY_W),
    .DEPTH (tpcd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_entry),
    .empty     (q_empty)
  );

  tpcd_back #(
    .ROM_BYTES (ROM_BYTES),
    .ADDR_W    (ADDR_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_entry  (head_entry),
    .q_pop    (q_pop),
    .len      (len),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: sv/tpcd_geom.sv
// ---------------------------------------------------------------------------
// Tile pattern color decoder view geometry
// Derives the byte base of the top visible row from the configuration.
// ---------------------------------------------------------------------------
module tpcd_geom #(
  parameter int TILES_PER_AXIS = tpcd_pkg::DEF_TILES_PER_AXIS,
  parameter int ADDR_W         = 19
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [ADDR_W-1:0]          len,
  input  logic [tpcd_pkg::TPR_W-1:0] tpr,
  input  logic [15:0]                scroll,
  output logic                       busy,
  output logic [ADDR_W-1:0]          base
);

  localparam int TW = ADDR_W - 3;
  localparam int CW = $clog2(TW + 1);

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_LOAD = 3'd1;
  localparam logic [2:0] G_DIV  = 3'd2;
  localparam logic [2:0] G_TOP  = 3'd3;
  localparam logic [2:0] G_MUL  = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic [TW-1:0] dvd;
  logic [TW-1:0] quo;
  logic [6:0]    rem;
  logic [15:0]   top;

  logic [TW-1:0] tiles;
  logic [6:0]    rem_sh;
  logic          fits;
  logic [TW:0]   rows;
  logic [TW:0]   max_top;
  logic [22:0]   top_tpr;

  assign tiles   = TW'((len + ADDR_W'(7)) >> 3);
  assign rem_sh  = {rem[5:0], dvd[TW-1]};
  assign fits    = rem_sh >= tpr;
  assign rows    = (TW+1)'(quo) + (TW+1)'(rem != 7'd0);
  assign max_top = (rows > (TW+1)'(TILES_PER_AXIS)) ? rows - (TW+1)'(TILES_PER_AXIS) : '0;
  assign top_tpr = 23'(top) * 23'(tpr);
  assign busy    = state != G_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      base  <= '0;
    end else if (restart) begin
      state <= G_LOAD;
    end else begin
      case (state)
        G_LOAD: begin
          dvd   <= tiles;
          quo   <= '0;
          rem   <= '0;
          cnt   <= CW'(TW);
          state <= G_DIV;
        end
        G_DIV: begin
          // Restoring division, one quotient bit per cycle.
          rem <= fits ? rem_sh - tpr : rem_sh;
          quo <= {quo[TW-2:0], fits};
          dvd <= {dvd[TW-2:0], 1'b0};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= G_TOP;
          end
        end
        G_TOP: begin
          top   <= ((TW+1)'(scroll) < max_top) ? scroll : 16'(max_top);
          state <= G_MUL;
        end
        G_MUL: begin
          base  <= ADDR_W'({top_tpr, 3'b000});
          state <= G_IDLE;
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/tpcd_front.sv
// ---------------------------------------------------------------------------
// Tile pattern color decoder front part
// Accepts items, classifies them and forms their store addresses.
// ---------------------------------------------------------------------------
module tpcd_front #(
  parameter int ROM_BYTES = tpcd_pkg::DEF_ROM_BYTES,
  parameter int ADDR_W    = 19,
  parameter int ENTRY_W   = 2 * ADDR_W + 11
) (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic                       op,
  input  logic [15:0]                write_addr,
  input  logic [7:0]                 write_byte,
  input  logic [5:0]                 row_idx,
  input  logic [5:0]                 col_idx,
  input  logic [2:0]                 line_in_tile,
  input  logic                       geom_busy,
  input  logic [ADDR_W-1:0]          base,
  input  logic [tpcd_pkg::TPR_W-1:0] tpr,
  input  logic [2:0]                 fine_offset,
  input  logic [1:0]                 color_mode,
  input  logic [15:0]                color_base,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [ENTRY_W-1:0]         q_entry
);

  logic [tpcd_pkg::TILE_W-1:0]     tile;
  logic [tpcd_pkg::LINE_OFF_W-1:0] line_off;
  logic [ADDR_W-1:0]               waddr;
  logic [ADDR_W-1:0]               paddr;
  logic [ADDR_W-1:0]               caddr;
  logic [ADDR_W-1:0]               addr_a;
  logic [1:0]                      kind;
  logic                            use_color;

  assign s_tready = !geom_busy && !q_full;
  assign q_push   = s_tvalid && s_tready;

  assign tile     = tpcd_pkg::TILE_W'(row_idx) * tpcd_pkg::TILE_W'(tpr)
                  + tpcd_pkg::TILE_W'(col_idx);
  assign line_off = {tile, line_in_tile};
  assign waddr    = ADDR_W'(write_addr);
  assign paddr    = base + ADDR_W'(fine_offset) + ADDR_W'(line_off);
  assign caddr    = ADDR_W'(color_base)
                  + ((color_mode == tpcd_pkg::MODE_LINE) ? ADDR_W'(line_off)
                                                         : ADDR_W'(tile >> 3));
  assign use_color = color_mode != tpcd_pkg::MODE_NONE;

  always_comb begin
    if (op == tpcd_pkg::OP_WRITE) begin
      kind   = (waddr < ADDR_W'(ROM_BYTES)) ? tpcd_pkg::KIND_WRITE : tpcd_pkg::KIND_SKIP;
      addr_a = waddr;
    end else begin
      kind   = ({1'b0, col_idx} < tpr) ? tpcd_pkg::KIND_RENDER : tpcd_pkg::KIND_BLANK;
      addr_a = paddr;
    end
  end

  assign q_entry = {kind, use_color, write_byte, caddr, addr_a};

endmodule

// File: sv/tpcd_queue.sv
// ---------------------------------------------------------------------------
// Tile pattern color decoder queue
// Short first-in first-out queue between the front and back parts.
// ---------------------------------------------------------------------------
module tpcd_queue #(
  parameter int W     = 49,
  parameter int DEPTH = tpcd_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full     = count == NW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

// File: sv/tpcd_back.sv
// ---------------------------------------------------------------------------
// Tile pattern color decoder back part
// Holds the byte store, makes the store accesses and forms the pixels.
// ---------------------------------------------------------------------------
module tpcd_back #(
  parameter int ROM_BYTES = tpcd_pkg::DEF_ROM_BYTES,
  parameter int ADDR_W    = 19,
  parameter int ENTRY_W   = 2 * ADDR_W + 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_entry,
  output logic               q_pop,
  input  logic [ADDR_W-1:0]  len,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  output logic               m_tuser
);

  localparam int AW = (ROM_BYTES > 1) ? $clog2(ROM_BYTES) : 1;

  localparam logic ST_ISSUE = 1'b0;
  localparam logic ST_FORM  = 1'b1;

  logic [7:0] store [ROM_BYTES];

  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [7:0]        wbyte;
  logic              use_color;
  logic [1:0]        kind;
  logic              is_write;
  logic              can_load;

  logic       state;
  logic       pat_ok;
  logic       col_ok;
  logic       col_used;
  logic [7:0] rd_pat;
  logic [7:0] rd_col;
  logic [7:0] pattern;
  logic [7:0] colors;
  logic [31:0] pixels;

  assign addr_a    = q_entry[ADDR_W-1:0];
  assign addr_b    = q_entry[2*ADDR_W-1:ADDR_W];
  assign wbyte     = q_entry[2*ADDR_W+7:2*ADDR_W];
  assign use_color = q_entry[2*ADDR_W+8];
  assign kind      = q_entry[2*ADDR_W+10:2*ADDR_W+9];

  assign is_write = (kind == tpcd_pkg::KIND_WRITE) || (kind == tpcd_pkg::KIND_SKIP);
  assign can_load = !m_tvalid || m_tready;
  assign q_pop    = !q_empty && (state == ST_ISSUE) && (is_write || can_load);

  always_ff @(posedge clk) begin
    if (q_pop && (kind == tpcd_pkg::KIND_WRITE)) begin
      store[addr_a[AW-1:0]] <= wbyte;
    end
    if (q_pop && (kind == tpcd_pkg::KIND_RENDER)) begin
      rd_pat <= store[addr_a[AW-1:0]];
      rd_col <= store[addr_b[AW-1:0]];
    end
  end

  // Bytes at or past the loaded length read as zero.
  assign pattern = pat_ok ? rd_pat : 8'h00;
  assign colors  = col_used ? (col_ok ? rd_col : 8'h00) : tpcd_pkg::COLOR_NONE;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pixels[4*i +: 4] = pattern[i] ? colors[7:4] : colors[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ISSUE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_ISSUE: begin
          if (q_pop && (kind == tpcd_pkg::KIND_BLANK)) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= 1'b0;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (q_pop && (kind == tpcd_pkg::KIND_RENDER)) begin
            pat_ok   <= addr_a < len;
            col_ok   <= addr_b < len;
            col_used <= use_color;
            state    <= ST_FORM;
          end
        end
        ST_FORM: begin
          // The output register was free when this item left the queue.
          m_tvalid <= 1'b1;
          m_tdata  <= pixels;
          m_tuser  <= 1'b1;
          state    <= ST_ISSUE;
        end
        default: begin
          state <= ST_ISSUE;
        end
      endcase
    end
  end

endmodule

// File: sv/tpcd_checker.sv
// ---------------------------------------------------------------------------
// Tile pattern color decoder checker
// Port-level checks on results and on the configuration lockout.
// ---------------------------------------------------------------------------
`include "tile_pattern_color_decoder_macros.svh"

module tpcd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tpcd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            cfg_we
);

  // A stalled result keeps its value.
  `TPCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // A line of an inactive column carries no pixels.
  `TPCD_ASSERT_SAME(a_blank_zero, m_tvalid && !m_tuser, m_tdata == '0, "inactive column with nonzero pixels")

  // New geometry is worked out after every register write, so no item is taken.
  `TPCD_ASSERT_NEXT(a_cfg_lock, cfg_we, !s_tready, "item taken while geometry is recomputed")

endmodule

bind tile_pattern_color_decoder tpcd_checker u_tpcd_checker (.*);
